### src/lsbm_pkg.sv
package lsbm_pkg;

	// Input word: millisecond time stamp and raw sensor reading.
	typedef struct packed {
		logic [31:0] time_ms;
		logic [11:0] adc_sample;
	} in_word_t;

	// Output word: held brightness and the sample-taken flag.
	typedef struct packed {
		logic [6:0] brightness;
		logic       sample_taken;
	} out_word_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 1'd1;

	// Register and state reset values.
	localparam logic [8:0]  RST_WEIGHT   = 9'd1;
	localparam logic [15:0] RST_INTERVAL = 16'd100;
	localparam logic [11:0] RST_LEVEL    = 12'd1969;
	localparam logic [6:0]  RST_BRIGHT   = 7'd35;

	// Table ends: clamp points and their brightness.
	localparam logic [11:0] MAP_X_FIRST = 12'd282;
	localparam logic [11:0] MAP_X_LAST  = 12'd3833;
	localparam logic [6:0]  MAP_Y_FIRST = 7'd100;
	localparam logic [6:0]  MAP_Y_LAST  = 7'd5;

	// Per-segment interpolation constants. The slope is negative in every
	// segment, so its magnitude is stored and the quotient is subtracted.
	localparam int RECIP_SHIFT = 20;
	localparam logic [11:0] SEG_X_LO  [4] = '{12'd282, 12'd1000, 12'd1969, 12'd3000};
	localparam logic [11:0] SEG_X_HI  [4] = '{12'd1000, 12'd1969, 12'd3000, 12'd3833};
	localparam logic [6:0]  SEG_Y_LO  [4] = '{7'd100, 7'd90, 7'd80, 7'd70};
	localparam logic [6:0]  SEG_DY    [4] = '{7'd10, 7'd10, 7'd10, 7'd65};
	localparam logic [10:0] SEG_DIV   [4] = '{11'd718, 11'd969, 11'd1031, 11'd833};
	// floor(2^RECIP_SHIFT / divisor); the estimate is low by at most one.
	localparam logic [10:0] SEG_RECIP [4] = '{11'd1460, 11'd1082, 11'd1017, 11'd1258};

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_UPDATE,
		ST_NUMER,
		ST_QUOT,
		ST_FIX,
		ST_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic ld_in;
		logic do_check;
		logic do_update;
		logic do_numer;
		logic do_quot;
		logic do_fix;
		logic ld_out;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic take;
	} status_t;

endpackage

### src/light_sensor_brightness_map_top.sv
// A sampled word steps through the check, update, numerator, quotient, fix and done
// states; an unsampled one goes from check to done. A new word is taken only in idle,
// after the last word is loaded into the output; done waits while output is stalled. The
// filter multiply and the reciprocal divide run as sequential steps of one controller.
// Reset: weight 1, sample_interval_ms 100, level 1969, brightness 35, no output.
module light_sensor_brightness_map_top #(
	parameter int LEVEL_FRAC_BITS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  lsbm_pkg::in_word_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output lsbm_pkg::out_word_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lsbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsbm_pkg::CFG_DATA_W-1:0] cfg_data
);

	lsbm_pkg::cmd_t    cmd;
	lsbm_pkg::status_t status;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	lsbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	lsbm_datapath #(
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

### src/lsbm_ctrl.sv
module lsbm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_stall,
	input  lsbm_pkg::status_t    status,
	output lsbm_pkg::cmd_t       cmd,
	output logic                 in_stall,
	output logic                 out_valid
);

	lsbm_pkg::state_t state_q;
	lsbm_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             out_free;

	// The output register can take a word when empty or being emptied.
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != lsbm_pkg::ST_IDLE);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lsbm_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = lsbm_pkg::ST_CHECK;
			end
			lsbm_pkg::ST_CHECK: begin
				state_nxt = status.take ? lsbm_pkg::ST_UPDATE : lsbm_pkg::ST_DONE;
			end
			lsbm_pkg::ST_UPDATE: state_nxt = lsbm_pkg::ST_NUMER;
			lsbm_pkg::ST_NUMER:  state_nxt = lsbm_pkg::ST_QUOT;
			lsbm_pkg::ST_QUOT:   state_nxt = lsbm_pkg::ST_FIX;
			lsbm_pkg::ST_FIX:    state_nxt = lsbm_pkg::ST_DONE;
			lsbm_pkg::ST_DONE: begin
				if (out_free) state_nxt = lsbm_pkg::ST_IDLE;
			end
			default: state_nxt = lsbm_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		case (state_q)
			lsbm_pkg::ST_IDLE:   cmd.ld_in     = in_valid;
			lsbm_pkg::ST_CHECK:  cmd.do_check  = 1'b1;
			lsbm_pkg::ST_UPDATE: cmd.do_update = 1'b1;
			lsbm_pkg::ST_NUMER:  cmd.do_numer  = 1'b1;
			lsbm_pkg::ST_QUOT:   cmd.do_quot   = 1'b1;
			lsbm_pkg::ST_FIX:    cmd.do_fix    = 1'b1;
			lsbm_pkg::ST_DONE:   cmd.ld_out    = out_free;
			default:             cmd = '0;
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsbm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/lsbm_datapath.sv
module lsbm_datapath #(
	parameter int LEVEL_FRAC_BITS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lsbm_pkg::cmd_t                  cmd,
	input  lsbm_pkg::in_word_t              in_data,
	input  logic                            cfg_we,
	input  logic [lsbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsbm_pkg::CFG_DATA_W-1:0] cfg_data,
	output lsbm_pkg::status_t               status,
	output lsbm_pkg::out_word_t             out_data
);

	localparam int LW = 12 + LEVEL_FRAC_BITS;
	localparam int PW = 23;
	localparam int SW = ((LW + 1 > PW) ? LW + 1 : PW) + 1;
	localparam int RECIP_SHIFT_LO = lsbm_pkg::RECIP_SHIFT;

	// Configuration and filter state.
	logic [8:0]   weight_q;
	logic [15:0]  interval_q;
	logic [LW-1:0] level_q;
	logic [31:0]  last_q;
	logic [6:0]   held_q;

	// Per-item working registers.
	logic [31:0]        time_q;
	logic [11:0]        smp_q;
	logic               taken_q;
	logic signed [PW-1:0] prod_q;
	logic [1:0]         seg_q;
	logic [6:0]         base_q;
	logic [15:0]        num_q;
	logic [6:0]         qt_q;
	lsbm_pkg::out_word_t out_q;

	// Elapsed time check and error product.
	logic [31:0]          elapsed;
	logic signed [12:0]   err;
	logic signed [PW-1:0] prod_nxt;
	logic [11:0]          lvl_int;

	assign lvl_int  = level_q[LW-1:LEVEL_FRAC_BITS];
	assign elapsed  = time_q - last_q;
	assign status.take = (elapsed >= {16'd0, interval_q});
	assign err      = $signed({1'b0, smp_q}) - $signed({1'b0, lvl_int});
	assign prod_nxt = PW'($signed({1'b0, weight_q}) * err);

	// Level update with saturation to the filter range.
	logic signed [SW-1:0] sum;
	logic [LW-1:0]        level_nxt;

	assign sum = $signed({{(SW-LW){1'b0}}, level_q}) + SW'(prod_q);

	always_comb begin
		if (sum < 0) begin
			level_nxt = '0;
		end else if (sum > $signed({{(SW-LW){1'b0}}, {LW{1'b1}}})) begin
			level_nxt = '1;
		end else begin
			level_nxt = sum[LW-1:0];
		end
	end

	// Segment select and interpolation numerator.
	logic [1:0]  seg_nxt;
	logic [6:0]  base_nxt;
	logic [15:0] num_nxt;
	logic [11:0] off;
	logic [18:0] mul19;

	always_comb begin
		if (lvl_int <= lsbm_pkg::SEG_X_HI[0]) begin
			seg_nxt = 2'd0;
		end else if (lvl_int <= lsbm_pkg::SEG_X_HI[1]) begin
			seg_nxt = 2'd1;
		end else if (lvl_int <= lsbm_pkg::SEG_X_HI[2]) begin
			seg_nxt = 2'd2;
		end else begin
			seg_nxt = 2'd3;
		end
		off   = lvl_int - lsbm_pkg::SEG_X_LO[seg_nxt];
		mul19 = {7'd0, off} * {12'd0, lsbm_pkg::SEG_DY[seg_nxt]};
		if (lvl_int <= lsbm_pkg::MAP_X_FIRST) begin
			base_nxt = lsbm_pkg::MAP_Y_FIRST;
			num_nxt  = '0;
		end else if (lvl_int >= lsbm_pkg::MAP_X_LAST) begin
			base_nxt = lsbm_pkg::MAP_Y_LAST;
			num_nxt  = '0;
		end else begin
			base_nxt = lsbm_pkg::SEG_Y_LO[seg_nxt];
			num_nxt  = mul19[15:0];
		end
	end

	// Quotient estimate by reciprocal multiplication.
	logic [26:0] qprod;
	assign qprod = {11'd0, num_q} * {16'd0, lsbm_pkg::SEG_RECIP[seg_q]};

	// Quotient correction and final brightness.
	logic [17:0] qd;
	logic [17:0] rem;
	logic [6:0]  q_fix;
	assign qd    = {11'd0, qt_q} * {7'd0, lsbm_pkg::SEG_DIV[seg_q]};
	assign rem   = {2'd0, num_q} - qd;
	assign q_fix = qt_q + 7'((rem >= {7'd0, lsbm_pkg::SEG_DIV[seg_q]}) ? 1 : 0);

	// Configuration registers and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q   <= lsbm_pkg::RST_WEIGHT;
			interval_q <= lsbm_pkg::RST_INTERVAL;
			level_q    <= LW'(lsbm_pkg::RST_LEVEL) << LEVEL_FRAC_BITS;
			last_q     <= '0;
			held_q     <= lsbm_pkg::RST_BRIGHT;
		end else begin
			if (cfg_we && cfg_index == lsbm_pkg::CFG_WEIGHT) begin
				weight_q <= cfg_data[8:0];
			end
			if (cfg_we && cfg_index == lsbm_pkg::CFG_SAMPLE_INTERVAL) begin
				interval_q <= cfg_data;
			end
			if (cmd.do_update) begin
				level_q <= level_nxt;
				last_q  <= time_q;
			end
			if (cmd.do_fix) begin
				held_q <= base_q - q_fix;
			end
		end
	end

	// Working registers for the item in flight.
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			time_q <= in_data.time_ms;
			smp_q  <= in_data.adc_sample;
		end
		if (cmd.do_check) begin
			taken_q <= status.take;
			prod_q  <= prod_nxt;
		end
		if (cmd.do_numer) begin
			seg_q  <= seg_nxt;
			base_q <= base_nxt;
			num_q  <= num_nxt;
		end
		if (cmd.do_quot) begin
			qt_q <= qprod[26:RECIP_SHIFT_LO];
		end
		if (cmd.ld_out) begin
			out_q.brightness   <= held_q;
			out_q.sample_taken <= taken_q;
		end
	end

	assign out_data = out_q;

endmodule

### verif/tb.sv
module tb;

	localparam int LEVEL_SHIFT = 4;
	localparam int LEVEL_TOP   = (4096 << LEVEL_SHIFT) - 1;
	localparam int KNEE_X [5]  = '{282, 1000, 1969, 3000, 3833};
	localparam int KNEE_Y [5]  = '{100, 90, 80, 70, 5};
	localparam int SWEEP [12]  = '{0, 282, 283, 1000, 1500, 1969, 2500, 3000, 3500, 3832,
		3833, 4095};
	localparam int PHASES      = 14;
	localparam int PHASE_WORDS = 130;

	// Tracks the filter level, the sample timer and the held brightness, and keeps
	// the brightness words still owed by the block.
	class brightness_tracker;
		logic [8:0]  weight;
		logic [15:0] interval_ms;
		int          level;
		logic [31:0] last_taken_ms;
		logic [6:0]  shown;
		lsbm_pkg::out_word_t pending_words[$];
		int          errors;

		function new();
			weight        = lsbm_pkg::RST_WEIGHT;
			interval_ms   = lsbm_pkg::RST_INTERVAL;
			level         = int'(lsbm_pkg::RST_LEVEL) << LEVEL_SHIFT;
			last_taken_ms = '0;
			shown         = lsbm_pkg::RST_BRIGHT;
			errors        = 0;
		endfunction

		function void write_reg(logic [lsbm_pkg::CFG_IDX_W-1:0] idx,
			logic [lsbm_pkg::CFG_DATA_W-1:0] data);
			if (idx == lsbm_pkg::CFG_WEIGHT) begin
				weight = data[8:0];
			end else if (idx == lsbm_pkg::CFG_SAMPLE_INTERVAL) begin
				interval_ms = data;
			end
		endfunction

		// Piecewise-linear map of the smoothed reading, clamped at both ends.
		function int percent_of(int v);
			int seg;
			int frac;
			if (v <= KNEE_X[0]) return KNEE_Y[0];
			if (v >= KNEE_X[4]) return KNEE_Y[4];
			seg = 0;
			while (v > KNEE_X[seg+1]) seg++;
			// The slope is negative, so the division truncates toward zero from below.
			frac = (v - KNEE_X[seg]) * (KNEE_Y[seg+1] - KNEE_Y[seg]);
			return KNEE_Y[seg] + frac / (KNEE_X[seg+1] - KNEE_X[seg]);
		endfunction

		// Works out the word that an accepted reading will produce.
		function void note_reading(lsbm_pkg::in_word_t w);
			logic [31:0] elapsed;
			longint      lvl;
			lsbm_pkg::out_word_t word;
			elapsed = w.time_ms - last_taken_ms;
			word.sample_taken = 1'b0;
			if (elapsed >= 32'(interval_ms)) begin
				lvl = longint'(level) + longint'(weight) *
					(longint'(w.adc_sample) - longint'(level >> LEVEL_SHIFT));
				if (lvl < 0) lvl = 0;
				if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
				level = int'(lvl);
				last_taken_ms = w.time_ms;
				shown = 7'(percent_of(level >> LEVEL_SHIFT));
				word.sample_taken = 1'b1;
			end
			word.brightness = shown;
			pending_words.push_back(word);
		endfunction

		// Compares a word from the block with the oldest one owed.
		function void check_word(lsbm_pkg::out_word_t got);
			lsbm_pkg::out_word_t want;
			if (pending_words.size() == 0) begin
				$error("unexpected word: brightness %0d sample_taken %0d",
					got.brightness, got.sample_taken);
				errors++;
				return;
			end
			want = pending_words.pop_front();
			if (got.brightness !== want.brightness) begin
				$error("brightness expected %0d got %0d", want.brightness, got.brightness);
				errors++;
			end
			if (got.sample_taken !== want.sample_taken) begin
				$error("sample_taken expected %0d got %0d", want.sample_taken,
					got.sample_taken);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	lsbm_pkg::in_word_t    in_data;
	logic                  out_valid;
	logic                  out_stall;
	lsbm_pkg::out_word_t   out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [lsbm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lsbm_pkg::CFG_DATA_W-1:0] cfg_data;

	brightness_tracker tracker = new;
	logic [31:0]       stamp_ms;
	bit                send_idle;
	bit                recv_idle;
	int                burst_left;
	int                hold_off_cycles;

	light_sensor_brightness_map_top #(
		.LEVEL_FRAC_BITS(LEVEL_SHIFT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap before the next input word; a burst forces back-to-back words.
	function automatic int sender_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		return send_idle ? int'($urandom_range(0, 4)) : 0;
	endfunction

	// Advances the millisecond clock, mostly around the sample interval.
	function automatic logic [31:0] next_stamp(logic [15:0] interval);
		int r;
		int span;
		r = $urandom_range(0, 99);
		span = int'(interval);
		if (r < 8) begin
			stamp_ms = $urandom;
		end else if (r < 14) begin
			stamp_ms += span;
		end else if (r < 20) begin
			stamp_ms += span - 1;
		end else if (r < 24) begin
			stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * span + 8);
		end else begin
			stamp_ms += $urandom_range(0, 2 * span + 3);
		end
		return stamp_ms;
	endfunction

	// Offers one reading and waits until the block takes it.
	task automatic offer(logic [31:0] t, logic [11:0] s);
		int       gap;
		lsbm_pkg::in_word_t w;
		gap = sender_gap();
		w.time_ms = t;
		w.adc_sample = s;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = w;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		tracker.note_reading(w);
		@(negedge clk);
	endtask

	// Waits until every owed word has come, then lets the block settle.
	task automatic drain();
		in_valid = 1'b0;
		while (tracker.pending_words.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [lsbm_pkg::CFG_IDX_W-1:0] idx,
		logic [lsbm_pkg::CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Reprograms both registers once the block is idle; the unused upper bits of
	// the weight write carry random data.
	task automatic program_regs(logic [8:0] weight, logic [15:0] interval);
		drain();
		if ($urandom_range(0, 1)) begin
			write_reg(lsbm_pkg::CFG_WEIGHT, {7'($urandom), weight});
			write_reg(lsbm_pkg::CFG_SAMPLE_INTERVAL, interval);
		end else begin
			write_reg(lsbm_pkg::CFG_SAMPLE_INTERVAL, interval);
			write_reg(lsbm_pkg::CFG_WEIGHT, {7'($urandom), weight});
		end
	endtask

	// Output side: random stalls, one long hold-off on request.
	initial begin
		int pause;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				pause = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				pause = recv_idle ? int'($urandom_range(0, 4)) : 0;
			end
			if (pause > 0) begin
				out_stall = 1'b1;
				repeat (pause) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			tracker.check_word(out_data);
			@(negedge clk);
		end
	end

	// Watchdog.
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Main sequence: directed corners, then randomized phases.
	initial begin
		int         p;
		int         k;
		logic [8:0]  weight;
		logic [15:0] interval;
		logic [11:0] s;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stamp_ms = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		burst_left = 0;
		hold_off_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: too early, exactly on the interval, then one short.
		offer(32'd0, 12'd0);
		offer(32'd100, 12'd4095);
		offer(32'd199, 12'd2000);

		// Full tracking with no interval: walk the table knees and both clamps.
		program_regs(9'd16, 16'd0);
		for (k = 0; k < 12; k++) begin
			offer((k == 0) ? 32'hFFFF_FFFF : $urandom, 12'(SWEEP[k]));
		end

		// Zero weight keeps the level but still recomputes the brightness.
		program_regs(9'd0, 16'd0);
		offer(32'd123, 12'd4095);

		// Overshooting weights saturate at both ends of the level range.
		program_regs(9'd256, 16'd0);
		offer(32'd0, 12'd0);
		offer(32'd1, 12'd4095);
		program_regs(9'd511, 16'd0);
		offer(32'd2, 12'd0);

		// Elapsed time across the 32-bit wrap.
		program_regs(9'd16, 16'd100);
		offer(32'hFFFF_FFF0, 12'd1500);
		offer(32'h0000_0050, 12'd3000);
		offer(32'h0000_0054, 12'd3000);
		stamp_ms = 32'h0000_0054;

		// Random phases, each with its own register setting and idling mix.
		for (p = 0; p < PHASES; p++) begin
			case (p % 7)
				0: weight = 9'd16;
				1: weight = 9'd1;
				2: weight = 9'($urandom_range(2, 15));
				3: weight = 9'd256;
				4: weight = 9'd0;
				5: weight = 9'($urandom_range(17, 255));
				default: weight = 9'd511;
			endcase
			case (p % 5)
				0: interval = 16'd0;
				1: interval = 16'd100;
				2: interval = 16'd65535;
				3: interval = 16'($urandom_range(1, 20));
				default: interval = 16'($urandom);
			endcase
			send_idle = (p % 3 != 1);
			recv_idle = (p % 4 != 2);
			program_regs(weight, interval);
			for (k = 0; k < PHASE_WORDS; k++) begin
				if (p == 1 && k == 20) begin
					// Output held off while input words keep coming.
					hold_off_cycles = 60;
					burst_left = 40;
				end
				if (p == 3 && k == 65) begin
					in_valid = 1'b0;
					while (tracker.pending_words.size() != 0) @(negedge clk);
				end
				if ($urandom_range(0, 9) == 0) begin
					s = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
				end else begin
					s = 12'($urandom_range(0, 4095));
				end
				offer(next_stamp(interval), s);
			end
		end

		drain();
		if (tracker.errors == 0 && tracker.pending_words.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
